/* design/bcse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcse_pkg
// Shared types, codes and fixed-point constants of the charge squared estimator.
// ----------------------------------------------------------------------------
package bcse_pkg;

  localparam int unsigned TIME_WINDOW_DEF = 160000;

  localparam int unsigned TIME_W  = 24;
  localparam int unsigned PEAK_W  = 21;
  localparam int unsigned DIFF_W  = 22;
  localparam int unsigned CAL_W   = 40;
  localparam int unsigned X_W     = 20;
  localparam int unsigned Z_W     = 48;
  localparam int unsigned ROOT_W  = 22;
  localparam int unsigned RAD_W   = 2 * ROOT_W;
  localparam int unsigned MUL_A_W = 41;
  localparam int unsigned MUL_B_W = 23;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned SQRT_STEPS = ROOT_W;

  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 6;

  // quadratic calibration: constant in Q.16, linear in Q.20, square term in Q.24
  localparam logic signed [MUL_P_W-1:0] Q_A_IN  = 64'sd88227218;
  localparam logic        [27:0]        Q_B_IN  = 28'd131042888;
  localparam logic        [16:0]        Q_C_IN  = 17'd49372;
  localparam logic signed [MUL_P_W-1:0] Q_A_OUT = 64'sd7436478;
  localparam logic        [27:0]        Q_B_OUT = 28'd165294393;
  localparam logic        [16:0]        Q_C_OUT = 17'd65979;

  localparam logic signed [MUL_P_W-1:0] HALF_LIN  = 64'sd524288;
  localparam logic signed [MUL_P_W-1:0] HALF_QUAD = 64'sd8388608;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_FIRST  = 2'd1,
    ACT_SECOND = 2'd2,
    ACT_FINISH = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_NEG     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_PED_FIRST_IN   = 3'd0,
    REG_PED_SECOND_IN  = 3'd1,
    REG_PED_FIRST_OUT  = 3'd2,
    REG_PED_SECOND_OUT = 3'd3,
    REG_CAL_SLOPE      = 3'd4,
    REG_CAL_OFFSET     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [PEAK_W-1:0] ped_first_in;
    logic signed [PEAK_W-1:0] ped_second_in;
    logic signed [PEAK_W-1:0] ped_first_out;
    logic signed [PEAK_W-1:0] ped_second_out;
    logic signed [CAL_W-1:0]  cal_slope;
    logic signed [CAL_W-1:0]  cal_offset;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

/* design/bcse_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcse_regs
// APB register file holding pedestals and linear calibration coefficients.
// ----------------------------------------------------------------------------
module bcse_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bcse_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [bcse_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [bcse_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output bcse_pkg::cfg_t                   cfg
);
  import bcse_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_PED_FIRST_IN:   cfg_nxt.ped_first_in   = pwdata[PEAK_W-1:0];
        REG_PED_SECOND_IN:  cfg_nxt.ped_second_in  = pwdata[PEAK_W-1:0];
        REG_PED_FIRST_OUT:  cfg_nxt.ped_first_out  = pwdata[PEAK_W-1:0];
        REG_PED_SECOND_OUT: cfg_nxt.ped_second_out = pwdata[PEAK_W-1:0];
        REG_CAL_SLOPE:      cfg_nxt.cal_slope      = pwdata[CAL_W-1:0];
        REG_CAL_OFFSET:     cfg_nxt.cal_offset     = pwdata[CAL_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PED_FIRST_IN:
        prdata = {{(APB_DATA_W-PEAK_W){cfg_r.ped_first_in[PEAK_W-1]}}, cfg_r.ped_first_in};
      REG_PED_SECOND_IN:
        prdata = {{(APB_DATA_W-PEAK_W){cfg_r.ped_second_in[PEAK_W-1]}}, cfg_r.ped_second_in};
      REG_PED_FIRST_OUT:
        prdata = {{(APB_DATA_W-PEAK_W){cfg_r.ped_first_out[PEAK_W-1]}}, cfg_r.ped_first_out};
      REG_PED_SECOND_OUT:
        prdata = {{(APB_DATA_W-PEAK_W){cfg_r.ped_second_out[PEAK_W-1]}},
                  cfg_r.ped_second_out};
      REG_CAL_SLOPE:
        prdata = {{(APB_DATA_W-CAL_W){cfg_r.cal_slope[CAL_W-1]}}, cfg_r.cal_slope};
      REG_CAL_OFFSET:
        prdata = {{(APB_DATA_W-CAL_W){cfg_r.cal_offset[CAL_W-1]}}, cfg_r.cal_offset};
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ped_first_in   <= 21'sd1109;
      cfg_r.ped_second_in  <= -21'sd188;
      cfg_r.ped_first_out  <= -21'sd408;
      cfg_r.ped_second_out <= 21'sd2017;
      cfg_r.cal_slope      <= '0;
      cfg_r.cal_offset     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* design/bcse_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcse_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module bcse_mul (
  input  logic                                clk,
  input  logic signed [bcse_pkg::MUL_A_W-1:0] op_a,
  input  logic signed [bcse_pkg::MUL_B_W-1:0] op_b,
  output logic signed [bcse_pkg::MUL_P_W-1:0] prod
);
  import bcse_pkg::*;

  logic signed [MUL_P_W-1:0] prod_r;
  logic signed [MUL_P_W-1:0] prod_nxt;

  assign prod_nxt = MUL_P_W'(op_a) * MUL_P_W'(op_b);
  assign prod     = prod_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

/* design/bcse_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcse_sqrt
// Iterative integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module bcse_sqrt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [bcse_pkg::RAD_W-1:0]       rad,
  output bcse_pkg::sqrt_stat_t             stat,
  output logic [bcse_pkg::ROOT_W-1:0]      root
);
  import bcse_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 3;
  localparam int unsigned CNT_W = $clog2(SQRT_STEPS + 1);

  logic [RAD_W-1:0]  rad_r,  rad_nxt;
  logic [REM_W-1:0]  rem_r,  rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r,  cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = rad;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(SQRT_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

endmodule

/* design/beam_charge_squared_estimator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beam_charge_squared_estimator_core
// Per-event nearest-digit selection, geometric mean amplitude and charge squared.
// ----------------------------------------------------------------------------
// Start and digit words: capture, then event state update; next word taken after.
// Finish word: pedestal product, 22-step square root unit, then the quadratic or
//   linear calibration; a missing counter or a negative product ends it early.
// All products share one registered multiplier; one word is in work at a time.
// A result word waits in the output register while the next word is taken.
// Synchronous active-low reset restores register defaults and clears the event.
module beam_charge_squared_estimator_core #(
  parameter int unsigned TIME_WINDOW = bcse_pkg::TIME_WINDOW_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             in_action,
  input  logic signed [bcse_pkg::TIME_W-1:0]     in_time_value,
  input  logic signed [bcse_pkg::PEAK_W-1:0]     in_peak,
  input  logic                                   in_is_incoming,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [1:0]                             out_status,
  output logic [bcse_pkg::X_W-1:0]               out_x_mean,
  output logic signed [bcse_pkg::Z_W-1:0]        out_z2,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [bcse_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [bcse_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [bcse_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                   pready
);
  import bcse_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_EXEC = 10'b00_0000_0010,
    S_PROD = 10'b00_0000_0100,
    S_SQRT = 10'b00_0000_1000,
    S_XSEL = 10'b00_0001_0000,
    S_LIN  = 10'b00_0010_0000,
    S_SQ   = 10'b00_0100_0000,
    S_CX2  = 10'b00_1000_0000,
    S_BX   = 10'b01_0000_0000,
    S_EMIT = 10'b10_0000_0000
  } state_t;

  localparam logic [TIME_W-1:0] WIN = TIME_W'(TIME_WINDOW);

  state_t state_r, state_nxt;

  cfg_t cfg;

  action_t                   act_r;
  logic signed [TIME_W-1:0]  time_r;
  logic signed [PEAK_W-1:0]  peak_r;
  logic                      inc_r;

  logic signed [TIME_W-1:0]  ref_time_r;
  logic                      dir_in_r;
  logic [TIME_W-1:0]         best_dt_r   [2];
  logic signed [PEAK_W-1:0]  best_peak_r [2];
  logic [1:0]                found_r;

  logic [X_W-1:0]            x_r, x_nxt;
  logic signed [MUL_P_W-1:0] acc_r, acc_nxt;
  status_t                   stat_r, stat_nxt;
  logic signed [Z_W-1:0]     z_r, z_nxt;

  logic                      out_valid_r;
  status_t                   out_status_r;
  logic [X_W-1:0]            out_x_r;
  logic signed [Z_W-1:0]     out_z_r;

  logic                      accept;
  logic                      out_take;
  logic                      out_free;

  logic signed [TIME_W:0]    dt;
  logic [TIME_W:0]           dt_abs;
  logic                      dig_sel;
  logic                      dig_hit;

  logic signed [DIFF_W-1:0]  diff_a, diff_b;
  logic signed [PEAK_W-1:0]  ped_a, ped_b;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  logic                      sqrt_start;
  sqrt_stat_t                sqrt_stat;
  logic [ROOT_W-1:0]         sqrt_root;

  logic                      lin_mode;
  logic signed [MUL_P_W-1:0] lin_sum;
  logic signed [MUL_P_W-1:0] lin_z;
  logic signed [MUL_P_W-1:0] quad_sum;
  logic signed [MUL_P_W-1:0] quad_z;
  logic signed [MUL_P_W-1:0] quad_a;
  logic [27:0]               quad_b;
  logic [16:0]               quad_c;

  bcse_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bcse_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  bcse_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (mul_p[RAD_W-1:0]),
    .stat  (sqrt_stat),
    .root  (sqrt_root)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_x_mean = out_x_r;
  assign out_z2     = out_z_r;

  // digit compare
  assign dt      = {time_r[TIME_W-1], time_r} - {ref_time_r[TIME_W-1], ref_time_r};
  assign dt_abs  = dt[TIME_W] ? (TIME_W+1)'(-dt) : dt;
  assign dig_sel = (act_r == ACT_SECOND);
  assign dig_hit = dt_abs < {1'b0, best_dt_r[dig_sel]};

  // pedestal subtraction
  assign ped_a  = dir_in_r ? cfg.ped_first_in  : cfg.ped_first_out;
  assign ped_b  = dir_in_r ? cfg.ped_second_in : cfg.ped_second_out;
  assign diff_a = {best_peak_r[0][PEAK_W-1], best_peak_r[0]} - {ped_a[PEAK_W-1], ped_a};
  assign diff_b = {best_peak_r[1][PEAK_W-1], best_peak_r[1]} - {ped_b[PEAK_W-1], ped_b};

  assign lin_mode = (cfg.cal_slope != '0) && (cfg.cal_offset != '0);
  assign quad_a   = dir_in_r ? Q_A_IN : Q_A_OUT;
  assign quad_b   = dir_in_r ? Q_B_IN : Q_B_OUT;
  assign quad_c   = dir_in_r ? Q_C_IN : Q_C_OUT;

  assign lin_sum  = mul_p
                  + {{(MUL_P_W-CAL_W-4){cfg.cal_offset[CAL_W-1]}}, cfg.cal_offset, 4'b0000}
                  + HALF_LIN;
  assign lin_z    = lin_sum >>> 20;
  assign quad_sum = acc_r + (mul_p <<< 4);
  assign quad_z   = quad_sum >>> 24;

  assign sqrt_start = (state_r == S_PROD) && !mul_p[MUL_P_W-1];

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_EXEC: begin
        mul_a = {{(MUL_A_W-DIFF_W){diff_a[DIFF_W-1]}}, diff_a};
        mul_b = {{(MUL_B_W-DIFF_W){diff_b[DIFF_W-1]}}, diff_b};
      end
      S_XSEL: begin
        if (lin_mode) begin
          mul_a = {{(MUL_A_W-CAL_W){cfg.cal_slope[CAL_W-1]}}, cfg.cal_slope};
        end else begin
          mul_a = {{(MUL_A_W-X_W){1'b0}}, x_r};
        end
        mul_b = {{(MUL_B_W-X_W){1'b0}}, x_r};
      end
      S_SQ: begin
        mul_a = mul_p[MUL_A_W-1:0];
        mul_b = {{(MUL_B_W-17){1'b0}}, quad_c};
      end
      S_CX2: begin
        mul_a = {{(MUL_A_W-28){1'b0}}, quad_b};
        mul_b = {{(MUL_B_W-X_W){1'b0}}, x_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    acc_nxt   = acc_r;
    stat_nxt  = stat_r;
    z_nxt     = z_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (act_r != ACT_FINISH) begin
          state_nxt = S_IDLE;
        end else if (found_r != 2'b11) begin
          stat_nxt  = ST_MISSING;
          x_nxt     = '0;
          z_nxt     = '0;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_PROD;
        end
      end
      S_PROD: begin
        if (mul_p[MUL_P_W-1]) begin
          stat_nxt  = ST_NEG;
          x_nxt     = '0;
          z_nxt     = '0;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sqrt_stat.done) begin
          stat_nxt  = ST_OK;
          x_nxt     = (sqrt_root[ROOT_W-1:X_W] != '0) ? '1 : sqrt_root[X_W-1:0];
          state_nxt = S_XSEL;
        end
      end
      S_XSEL: begin
        state_nxt = lin_mode ? S_LIN : S_SQ;
      end
      S_LIN: begin
        z_nxt     = lin_z[Z_W-1:0];
        state_nxt = S_EMIT;
      end
      S_SQ: begin
        state_nxt = S_CX2;
      end
      S_CX2: begin
        acc_nxt   = mul_p + (quad_a <<< 8) + HALF_QUAD;
        state_nxt = S_BX;
      end
      S_BX: begin
        z_nxt     = quad_z[Z_W-1:0];
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      ref_time_r     <= '0;
      dir_in_r       <= 1'b0;
      best_dt_r[0]   <= WIN;
      best_dt_r[1]   <= WIN;
      best_peak_r[0] <= '0;
      best_peak_r[1] <= '0;
      found_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_EXEC) begin
        if (act_r == ACT_START) begin
          ref_time_r     <= time_r;
          dir_in_r       <= inc_r;
          best_dt_r[0]   <= WIN;
          best_dt_r[1]   <= WIN;
          best_peak_r[0] <= '0;
          best_peak_r[1] <= '0;
          found_r        <= '0;
        end else if (act_r != ACT_FINISH && dig_hit) begin
          best_dt_r[dig_sel]   <= dt_abs[TIME_W-1:0];
          best_peak_r[dig_sel] <= peak_r;
          found_r[dig_sel]     <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= action_t'(in_action);
      time_r <= in_time_value;
      peak_r <= in_peak;
      inc_r  <= in_is_incoming;
    end
    x_r    <= x_nxt;
    acc_r  <= acc_nxt;
    stat_r <= stat_nxt;
    z_r    <= z_nxt;
    if (state_r == S_EMIT && out_free) begin
      out_status_r <= stat_r;
      out_x_r      <= x_r;
      out_z_r      <= z_r;
    end
  end

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result word raised outside emit");

  a_sqrt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_start |-> !sqrt_stat.busy)
    else $error("square root restarted while busy");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_x_r == '0 && out_z_r == '0))
    else $error("failed event carries nonzero fields");

  a_found_win0: assert property (@(posedge clk) disable iff (!rst_n)
    found_r[0] |-> (best_dt_r[0] < WIN))
    else $error("first counter kept digit outside window");

  a_found_win1: assert property (@(posedge clk) disable iff (!rst_n)
    found_r[1] |-> (best_dt_r[1] < WIN))
    else $error("second counter kept digit outside window");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the beam charge squared estimator core.
// Start, digit and finish words go in with random gaps; results come out against
// random output stalls and one long hold-off. Finish results are checked field
// by field against a behavioral model of the event state or a typed expected
// result. The run walks the reset values and five APB-written register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import bcse_pkg::*;

  localparam longint WINDOW = TIME_WINDOW_DEF;
  localparam longint X_SAT  = 1048575;
  localparam int     T_MAX  = 8388607;
  localparam int     T_MIN  = -8388608;
  localparam int     P_MAX  = 1048575;
  localparam int     P_MIN  = -1048576;
  // quadratic calibration: constant in Q.16, linear in Q.20, square term in Q.24
  localparam longint QA_IN  = 88227218;
  localparam longint QB_IN  = 131042888;
  localparam longint QC_IN  = 49372;
  localparam longint QA_OUT = 7436478;
  localparam longint QB_OUT = 165294393;
  localparam longint QC_OUT = 65979;

  typedef struct packed {
    status_t          st;
    logic [X_W-1:0]   xm;
    logic [Z_W-1:0]   zv;
  } charge_res_t;

  typedef struct {
    action_t act;
    int      tv;
    int      pk;
    bit      inc;
    bit      typed;
    status_t st;
    int      xm;
    longint  zv;
  } opening_row_t;

  logic                         clk;
  logic                         rst_n          = 1'b0;
  logic                         in_valid       = 1'b0;
  logic                         in_stall;
  logic [1:0]                   in_action      = ACT_START;
  logic signed [TIME_W-1:0]     in_time_value  = '0;
  logic signed [PEAK_W-1:0]     in_peak        = '0;
  logic                         in_is_incoming = 1'b0;
  logic                         out_valid;
  logic                         out_stall      = 1'b0;
  logic [1:0]                   out_status;
  logic [X_W-1:0]               out_x_mean;
  logic signed [Z_W-1:0]        out_z2;
  logic                         psel           = 1'b0;
  logic                         penable        = 1'b0;
  logic                         pwrite         = 1'b0;
  logic [APB_ADDR_W-1:0]        paddr          = '0;
  logic [APB_DATA_W-1:0]        pwdata         = '0;
  logic [APB_DATA_W-1:0]        prdata;
  logic                         pready;

  beam_charge_squared_estimator_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_time_value  (in_time_value),
    .in_peak        (in_peak),
    .in_is_incoming (in_is_incoming),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_x_mean     (out_x_mean),
    .out_z2         (out_z2),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** beam_charge_squared_estimator_core: FAILED **");
    $finish;
  end

  // event state and register copy of the estimator
  longint ev_ref;
  bit     ev_incoming;
  longint near_dt [2];
  longint near_peak [2];
  bit     near_found [2];
  longint ped_in [2];
  longint ped_out [2];
  longint cal_k;
  longint cal_c;

  charge_res_t charge_due [$];
  int words_sent   = 0;
  int results_seen = 0;
  int errors       = 0;
  int n_ok         = 0;
  int n_missing    = 0;
  int n_neg        = 0;
  int n_sat        = 0;

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned r;
    r = 0;
    for (int i = 31; i >= 0; i--)
      if (((r | (64'd1 << i)) * (r | (64'd1 << i))) <= n) r |= 64'd1 << i;
    return r;
  endfunction

  function automatic void clear_event();
    for (int i = 0; i < 2; i++) begin
      near_dt[i]    = WINDOW;
      near_peak[i]  = 0;
      near_found[i] = 1'b0;
    end
  endfunction

  function automatic bit estimate_word(input action_t act, input longint tv, input longint pk,
                                       input bit inc, output charge_res_t res);
    longint a;
    longint b;
    longint prod;
    longint xm;
    longint acc;
    int     ch;
    res = '0;
    if (act == ACT_START) begin
      ev_ref      = tv;
      ev_incoming = inc;
      clear_event();
      return 1'b0;
    end
    if (act != ACT_FINISH) begin
      ch = (act == ACT_FIRST) ? 0 : 1;
      a  = tv - ev_ref;
      if (a < 0) a = -a;
      if (a < near_dt[ch]) begin
        near_dt[ch]    = a;
        near_peak[ch]  = pk;
        near_found[ch] = 1'b1;
      end
      return 1'b0;
    end
    if (!near_found[0] || !near_found[1]) begin
      res.st = ST_MISSING;
      return 1'b1;
    end
    a    = near_peak[0] - (ev_incoming ? ped_in[0] : ped_out[0]);
    b    = near_peak[1] - (ev_incoming ? ped_in[1] : ped_out[1]);
    prod = a * b;
    if (prod < 0) begin
      res.st = ST_NEG;
      return 1'b1;
    end
    xm = longint'(root_floor(prod));
    if (xm > X_SAT) xm = X_SAT;
    if (cal_k != 0 && cal_c != 0)
      acc = (cal_k * xm + cal_c * 16 + 64'sd524288) >>> 20;
    else if (ev_incoming)
      acc = (QC_IN * xm * xm + QB_IN * xm * 16 + QA_IN * 256 + 64'sd8388608) >>> 24;
    else
      acc = (QC_OUT * xm * xm + QB_OUT * xm * 16 + QA_OUT * 256 + 64'sd8388608) >>> 24;
    res.st = ST_OK;
    res.xm = xm[X_W-1:0];
    res.zv = acc[Z_W-1:0];
    return 1'b1;
  endfunction

  task automatic send_word(input action_t act, input longint tv, input longint pk, input bit inc,
                           input bit typed, input charge_res_t typed_res);
    charge_res_t r;
    bit          calm;
    calm = (words_sent >= 900 && words_sent < 1100);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_time_value  <= tv[TIME_W-1:0];
    in_peak        <= pk[PEAK_W-1:0];
    in_is_incoming <= inc;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (estimate_word(act, longint'($signed(tv[TIME_W-1:0])),
                      longint'($signed(pk[PEAK_W-1:0])), inc, r)) begin
      case (r.st)
        ST_OK:      n_ok++;
        ST_MISSING: n_missing++;
        default:    n_neg++;
      endcase
      if (r.st == ST_OK && r.xm == X_W'(X_SAT)) n_sat++;
      charge_due.push_back(typed ? typed_res : r);
    end
  endtask

  task automatic random_words(input int n);
    int          first_word;
    int          digits;
    longint      tref;
    longint      span;
    longint      off;
    bit          inc;
    charge_res_t none;
    none       = '0;
    first_word = words_sent;
    while (words_sent - first_word < n) begin
      if ($urandom_range(99) < 85) begin
        tref = longint'($signed(24'($urandom)));
        inc  = 1'($urandom_range(1));
        send_word(ACT_START, tref, longint'($urandom), inc, 1'b0, none);
        digits = $urandom_range(6);
        repeat (digits) begin
          span = ($urandom_range(3) == 0) ? 200000 : 2000;
          off  = longint'($urandom_range(32'(2 * span))) - span;
          send_word(action_t'($urandom_range(2, 1)), tref + off,
                    $urandom_range(1) ? longint'($urandom)
                                      : longint'($urandom_range(24000)) - 4000,
                    1'($urandom_range(1)), 1'b0, none);
        end
        send_word(ACT_FINISH, longint'($urandom), longint'($urandom), 1'($urandom_range(1)),
                  1'b0, none);
        if ($urandom_range(6) == 0)
          send_word(ACT_FINISH, longint'($urandom), longint'($urandom),
                    1'($urandom_range(1)), 1'b0, none);
      end else begin
        send_word(action_t'($urandom_range(3)), longint'($urandom), longint'($urandom),
                  1'($urandom_range(1)), 1'b0, none);
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (charge_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input longint val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(8 * idx);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_PED_FIRST_IN:   ped_in[0]  = longint'($signed(val[PEAK_W-1:0]));
      REG_PED_SECOND_IN:  ped_in[1]  = longint'($signed(val[PEAK_W-1:0]));
      REG_PED_FIRST_OUT:  ped_out[0] = longint'($signed(val[PEAK_W-1:0]));
      REG_PED_SECOND_OUT: ped_out[1] = longint'($signed(val[PEAK_W-1:0]));
      REG_CAL_SLOPE:      cal_k      = longint'($signed(val[CAL_W-1:0]));
      REG_CAL_OFFSET:     cal_c      = longint'($signed(val[CAL_W-1:0]));
      default: ;
    endcase
  endtask

  task automatic set_regs(input longint pf_in, input longint ps_in, input longint pf_out,
                          input longint ps_out, input longint slope, input longint offset);
    write_reg(REG_PED_FIRST_IN, pf_in);
    write_reg(REG_PED_SECOND_IN, ps_in);
    write_reg(REG_PED_FIRST_OUT, pf_out);
    write_reg(REG_PED_SECOND_OUT, ps_out);
    write_reg(REG_CAL_SLOPE, slope);
    write_reg(REG_CAL_OFFSET, offset);
  endtask

  opening_row_t opening [24] = '{
    '{ACT_FINISH, 0, 0, 1'b0, 1'b1, ST_MISSING, 0, 0},
    '{ACT_FIRST, 100, 5000, 1'b0, 1'b0, ST_OK, 0, 0},
    '{ACT_SECOND, -100, 3000, 1'b0, 1'b0, ST_OK, 0, 0},
    '{ACT_FINISH, 0, 0, 1'b0, 1'b0, ST_OK, 0, 0},
    '{ACT_START, T_MAX, 0, 1'b1, 1'b0, ST_OK, 0, 0},
    '{ACT_FIRST, T_MAX, P_MAX, 1'b0, 1'b0, ST_OK, 0, 0},
    '{ACT_SECOND, T_MIN, P_MIN, 1'b0, 1'b0, ST_OK, 0, 0},
    '{ACT_FINISH, 0, 0, 1'b0, 1'b1, ST_MISSING, 0, 0},
    '{ACT_SECOND, T_MAX - 159999, P_MIN, 1'b0, 1'b0, ST_OK, 0, 0},
    '{ACT_FINISH, 0, 0, 1'b0, 1'b1, ST_NEG, 0, 0},
    '{ACT_START, T_MIN, 0, 1'b0, 1'b0, ST_OK, 0, 0},
    '{ACT_FIRST, T_MIN + 160000, 100, 1'b0, 1'b0, ST_OK, 0, 0},
    '{ACT_SECOND, T_MIN, P_MIN, 1'b0, 1'b0, ST_OK, 0, 0},
    '{ACT_FINISH, 0, 0, 1'b0, 1'b1, ST_MISSING, 0, 0},
    '{ACT_FIRST, T_MIN, P_MIN, 1'b0, 1'b0, ST_OK, 0, 0},
    '{ACT_FINISH, 0, 0, 1'b0, 1'b0, ST_OK, 0, 0},
    '{ACT_FIRST, T_MIN, 0, 1'b0, 1'b0, ST_OK, 0, 0},
    '{ACT_FINISH, T_MAX, P_MAX, 1'b1, 1'b0, ST_OK, 0, 0},
    '{ACT_START, 0, 0, 1'b1, 1'b0, ST_OK, 0, 0},
    '{ACT_FIRST, 5, 1109, 1'b0, 1'b0, ST_OK, 0, 0},
    '{ACT_SECOND, -5, 2000, 1'b0, 1'b0, ST_OK, 0, 0},
    '{ACT_FINISH, 0, 0, 1'b0, 1'b0, ST_OK, 0, 0},
    '{ACT_START, -1, P_MAX, 1'b1, 1'b0, ST_OK, 0, 0},
    '{ACT_FINISH, 0, 0, 1'b0, 1'b1, ST_MISSING, 0, 0}
  };

  initial begin : stimulus
    charge_res_t tr;
    ped_in[0]  = 1109;
    ped_in[1]  = -188;
    ped_out[0] = -408;
    ped_out[1] = 2017;
    cal_k      = 0;
    cal_c      = 0;
    ev_ref      = 0;
    ev_incoming = 1'b0;
    clear_event();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening[i]) begin
      tr = '{opening[i].st, opening[i].xm[X_W-1:0], opening[i].zv[Z_W-1:0]};
      send_word(opening[i].act, longint'(opening[i].tv), longint'(opening[i].pk),
                opening[i].inc, opening[i].typed, tr);
    end
    random_words(250);

    settle();
    set_regs(0, 0, 0, 0, longint'($urandom) + 1, -(longint'($urandom_range(1 << 30)) + 1));
    random_words(260);

    settle();
    set_regs(P_MIN, P_MIN, P_MIN, P_MIN, 64'sd549755813887, -64'sd549755813888);
    random_words(260);

    settle();
    set_regs(P_MAX, P_MAX, P_MAX, P_MAX, 12345, 0);
    random_words(260);

    settle();
    set_regs(longint'($urandom_range(4000)) - 2000, longint'($urandom_range(4000)) - 2000,
             longint'($urandom_range(4000)) - 2000, longint'($urandom_range(4000)) - 2000,
             -64'sd549755813888, 64'sd549755813887);
    random_words(260);

    settle();
    set_regs(longint'($urandom_range(300)), -longint'($urandom_range(300)),
             longint'($urandom_range(300)), -longint'($urandom_range(300)), 0, 77777);
    random_words(260);

    settle();
    $display("Run covered %0d input words and %0d result words over six register settings,",
             words_sent, results_seen);
    $display("with %0d good, %0d missing-counter, %0d negative-product results, %0d saturated.",
             n_ok, n_missing, n_neg, n_sat);
    if (errors == 0)
      $display("** beam_charge_squared_estimator_core: PASSED **");
    else
      $display("** beam_charge_squared_estimator_core: FAILED **");
    $finish;
  end

  initial begin : result_side
    charge_res_t exp_res;
    bit          held;
    bit          calm;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        results_seen++;
        if (charge_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word: status %0d x_mean %0d z2 %0d",
                   $time, out_status, out_x_mean, out_z2);
        end else begin
          exp_res = charge_due.pop_front();
          if (out_status !== exp_res.st) begin
            errors++;
            $display("%0t: status expected %0d, got %0d", $time, exp_res.st, out_status);
          end
          if (out_x_mean !== exp_res.xm) begin
            errors++;
            $display("%0t: x_mean expected %0d, got %0d", $time, exp_res.xm, out_x_mean);
          end
          if (out_z2 !== exp_res.zv) begin
            errors++;
            $display("%0t: z2 expected %0d, got %0d", $time, $signed(exp_res.zv), out_z2);
          end
        end
      end
      calm = (results_seen >= 150 && results_seen < 230);
      if (results_seen == 40 && !held) begin
        // hold off long enough for the core to back up into its input
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 18);
      end
    end
  end

endmodule
